// ----- rtl/ffra_pkg.sv -----
`timescale 1ns / 1ps

package ffra_pkg;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [1:0] STATUS_LIST_FULL = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_SCAN,
      S_TRIM,
      S_SHIFT,
      S_BUMP,
      S_RESP
   } state_type;

endpackage

// ----- rtl/ffra_ram.sv -----
`timescale 1ns / 1ps

module ffra_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/first_fit_range_allocator.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   operation, range_length, range_start
// rsp_      out        rsp_valid/rsp_stall   status, granted_start
// csr_      in         csr_write_enable      csr_write_data (buffer capacity)
//
// A free appends in S_START unless the list is full and loads its result in S_RESP.
// An allocate reads one list entry per cycle through the list memory's single read port:
// an empty list goes straight to the bump region, a hit with room to spare is trimmed from
// its front, an exact fit moves later entries down one per cycle; a miss tries the bump region.
// Reset clears the entry count, the bump pointer and the capacity (to all ones); the list
// memory is not cleared. req_stall is high while an item is in work and the next item can be
// accepted in the cycle after the result loads; a stalled result holds in the output register
// while the next item is already accepted, and delays the load of the following result.
module first_fit_range_allocator
   import ffra_pkg::*;
#(
   parameter int FREE_LIST_DEPTH = 64,
   parameter int UNIT_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [UNIT_BITS-1:0] req_range_length,
   input  logic [UNIT_BITS-1:0] req_range_start,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [UNIT_BITS-1:0] rsp_granted_start,
   input  logic                 csr_write_enable,
   input  logic [UNIT_BITS-1:0] csr_write_data
);

   localparam int IDX_W = (FREE_LIST_DEPTH > 1) ? $clog2(FREE_LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(FREE_LIST_DEPTH + 1);
   localparam int ENT_W = 2 * UNIT_BITS;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [UNIT_BITS-1:0] bump_ff, bump_in;
   logic [UNIT_BITS-1:0] cap_ff, cap_in;
   logic                 op_ff, op_in;
   logic [UNIT_BITS-1:0] len_ff, len_in;
   logic [UNIT_BITS-1:0] start_ff, start_in;
   logic [UNIT_BITS-1:0] rest_ff, rest_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic [UNIT_BITS-1:0] res_grant_ff, res_grant_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [UNIT_BITS-1:0] rsp_grant_ff, rsp_grant_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [ENT_W-1:0]     ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   logic [ENT_W-1:0]     ram_rdata;

   logic [UNIT_BITS-1:0] rd_start;
   logic [UNIT_BITS-1:0] rd_len;
   logic [UNIT_BITS:0]   diff;
   logic                 fits;
   logic                 exact;
   logic [CNT_W-1:0]     idx_p1;
   logic [CNT_W-1:0]     idx_p2;
   logic [UNIT_BITS:0]   bump_sum;

   ffra_ram #(
      .WIDTH(ENT_W),
      .DEPTH(FREE_LIST_DEPTH)
   ) u_list (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Split the entry and run the shared length compare
   assign rd_start = ram_rdata[ENT_W-1:UNIT_BITS];
   assign rd_len   = ram_rdata[UNIT_BITS-1:0];
   assign diff     = {1'b0, rd_len} - {1'b0, len_ff};
   assign fits     = ~diff[UNIT_BITS];
   assign exact    = (diff[UNIT_BITS-1:0] == '0);
   assign idx_p1   = idx_ff + CNT_W'(1);
   assign idx_p2   = idx_ff + CNT_W'(2);
   assign bump_sum = {1'b0, bump_ff} + {1'b0, len_ff};

   // Sequence one item through the list
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      bump_in       = bump_ff;
      cap_in        = cap_ff;
      op_in         = op_ff;
      len_in        = len_ff;
      start_in      = start_ff;
      rest_in       = rest_ff;
      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff[IDX_W-1:0];
      ram_wdata     = ram_rdata;
      ram_raddr     = idx_p1[IDX_W-1:0];

      if (csr_write_enable) begin
         cap_in = csr_write_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               len_in   = req_range_length;
               start_in = req_range_start;
               state_in = S_START;
            end
         end
         S_START: begin
            res_grant_in = '0;
            if (op_ff) begin
               // Append a freed range unless the list is full
               if (count_ff >= CNT_W'(FREE_LIST_DEPTH)) begin
                  res_status_in = STATUS_LIST_FULL;
               end else begin
                  ram_we        = 1'b1;
                  ram_waddr     = count_ff[IDX_W-1:0];
                  ram_wdata     = {start_ff, len_ff};
                  count_in      = count_ff + CNT_W'(1);
                  res_status_in = STATUS_OK;
               end
               state_in = S_RESP;
            end else if (count_ff == '0) begin
               state_in = S_BUMP;
            end else begin
               ram_raddr = '0;
               idx_in    = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            // Check entry idx, fetch the next one
            if (fits) begin
               res_status_in = STATUS_OK;
               res_grant_in  = rd_start;
               if (!exact) begin
                  rest_in  = diff[UNIT_BITS-1:0];
                  state_in = S_TRIM;
               end else if (idx_p1 >= count_ff) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_RESP;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (idx_p1 >= count_ff) begin
               state_in = S_BUMP;
            end else begin
               idx_in = idx_p1;
            end
         end
         S_TRIM: begin
            // Trim the hit entry from its front
            ram_we    = 1'b1;
            ram_wdata = {res_grant_ff + len_ff, rest_ff};
            state_in  = S_RESP;
         end
         S_SHIFT: begin
            // Move the later entry down one place
            ram_we    = 1'b1;
            ram_raddr = idx_p2[IDX_W-1:0];
            if (idx_p2 >= count_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end else begin
               idx_in = idx_p1;
            end
         end
         S_BUMP: begin
            // Grow the bump region if the capacity allows
            if (bump_sum > {1'b0, cap_ff}) begin
               res_status_in = STATUS_NO_SPACE;
               res_grant_in  = '0;
            end else begin
               res_status_in = STATUS_OK;
               res_grant_in  = bump_ff;
               bump_in       = bump_sum[UNIT_BITS-1:0];
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_grant_in  = res_grant_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         bump_ff      <= '0;
         cap_ff       <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bump_ff      <= bump_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      op_ff         <= op_in;
      len_ff        <= len_in;
      start_ff      <= start_in;
      rest_ff       <= rest_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_start = rsp_grant_ff;

endmodule

// ----- rtl/ffra_checker.sv -----
`timescale 1ns / 1ps

module ffra_checker
   import ffra_pkg::*;
#(
   parameter int UNIT_BITS = 24
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [1:0]           rsp_status,
   input logic [UNIT_BITS-1:0] rsp_granted_start
);

   // Hold a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted_start))
      else $error("stalled result item changed");

   // Report no start on a failed allocate or on a failed free
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_granted_start == '0)
      else $error("failed item carries a start");

   // Go busy after each accepted item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block ready right after accepting an item");

   // Drop results out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or busy flag present after reset");

endmodule

bind first_fit_range_allocator ffra_checker #(
   .UNIT_BITS(UNIT_BITS)
) u_ffra_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_granted_start(rsp_granted_start)
);
